@@ rtl/ple_pkg.sv @@
// Shared constants, operation codes and the chain control struct for the
// positional list engine. No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 4;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int LEN_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND       = 4'd0,
        OP_PREPEND      = 4'd1,
        OP_INSERT_AT    = 4'd2,
        OP_POP_FRONT    = 4'd3,
        OP_POP_BACK     = 4'd4,
        OP_REMOVE_AT    = 4'd5,
        OP_REMOVE_VALUE = 4'd6,
        OP_REMOVE_EVEN  = 4'd7,
        OP_READ_AT      = 4'd8
    } op_t;

    // Broadcast to every cell once per cycle.
    typedef struct packed {
        logic             shift;       // every cell takes its right neighbor
        logic             load;        // the target cell takes load_value
        logic [IDX_W-1:0] tgt;
        logic [VAL_W-1:0] load_value;
    } chain_ctl_t;

endpackage

@@ rtl/ple_cell.sv @@
// One storage cell of the list chain: holds one element and hands it left.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_cell (
    input  logic                     clk,
    input  ple_pkg::chain_ctl_t      ctl,
    input  logic                     sel,
    input  logic [ple_pkg::VAL_W-1:0] right_value,
    output logic [ple_pkg::VAL_W-1:0] value
);
    import ple_pkg::*;

    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.load && sel)
        begin
            value_next = ctl.load_value;
        end
        else if (ctl.shift)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

@@ rtl/ple_ctrl.sv @@
// Sequencer for the positional list engine: decodes an item, walks the chain
// one rotation step per cycle and holds count and result. Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ple_pkg::OP_W-1:0]  operation,
    input  logic [ple_pkg::POS_W-1:0] position,
    input  logic [ple_pkg::VAL_W-1:0] item_value,
    input  logic [ple_pkg::VAL_W-1:0] front_value,
    output ple_pkg::chain_ctl_t       chain,
    output logic                      done,
    output logic                      ok,
    output logic [ple_pkg::VAL_W-1:0] result_value,
    output logic [ple_pkg::LEN_W-1:0] length_after
);
    import ple_pkg::*;

    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [VAL_W-1:0] res_reg, res_next;
    logic             ok_reg, ok_next;

    logic             go;
    logic             ins;
    logic [CNT_W-1:0] idx_dec;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic             is_tgt;
    logic             do_push;
    logic             do_drop;
    logic             capture;

    assign pos_x  = CMP_W'(position);
    assign cnt_x  = CMP_W'(count_reg);
    assign is_tgt = (step_reg == idx_reg);

    // item decode
    always_comb
    begin
        go      = 1'b0;
        ins     = 1'b0;
        idx_dec = '0;
        case (operation)
            OP_APPEND:
            begin
                ins     = 1'b1;
                go      = (cnt_x < CMP_W'(CAPACITY));
                idx_dec = count_reg;
            end
            OP_PREPEND:
            begin
                ins = 1'b1;
                go  = (cnt_x < CMP_W'(CAPACITY));
            end
            OP_INSERT_AT:
            begin
                ins     = 1'b1;
                go      = (cnt_x < CMP_W'(CAPACITY)) && (pos_x != '0)
                          && (pos_x <= cnt_x + CMP_W'(1));
                idx_dec = CNT_W'(pos_x - CMP_W'(1));
            end
            OP_POP_FRONT:
            begin
                go = (count_reg != '0);
            end
            OP_POP_BACK:
            begin
                go      = (count_reg != '0);
                idx_dec = count_reg - CNT_W'(1);
            end
            OP_REMOVE_AT, OP_READ_AT:
            begin
                go      = (pos_x != '0) && (pos_x <= cnt_x);
                idx_dec = CNT_W'(pos_x - CMP_W'(1));
            end
            OP_REMOVE_VALUE, OP_REMOVE_EVEN:
            begin
                go = (count_reg != '0);
            end
            default:
            begin
                go = 1'b0;
            end
        endcase
    end

    // per-step action
    always_comb
    begin
        do_push = 1'b0;
        do_drop = 1'b0;
        capture = 1'b0;
        case (op_reg)
            OP_APPEND, OP_PREPEND, OP_INSERT_AT:
            begin
                do_push = is_tgt;
            end
            OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT:
            begin
                do_drop = is_tgt;
                capture = is_tgt;
            end
            OP_REMOVE_VALUE:
            begin
                do_drop = !ok_reg && (front_value == val_reg);
                capture = do_drop;
            end
            OP_REMOVE_EVEN:
            begin
                do_drop = !front_value[0];
            end
            OP_READ_AT:
            begin
                capture = is_tgt;
            end
            default:
            begin
                do_push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        steps_next = steps_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        res_next   = res_reg;
        ok_next    = ok_reg;

        chain.shift      = 1'b0;
        chain.load       = 1'b0;
        chain.tgt        = '0;
        chain.load_value = val_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    val_next   = item_value;
                    idx_next   = idx_dec;
                    step_next  = '0;
                    steps_next = ins ? (count_reg + CNT_W'(1)) : count_reg;
                    res_next   = '0;
                    ok_next    = go && (operation != OP_REMOVE_VALUE);
                    state_next = go ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN:
            begin
                // push: write at tail, rot: front to tail, drop: front leaves
                chain.shift      = !do_push;
                chain.load       = !do_drop;
                chain.tgt        = do_push ? IDX_W'(count_reg)
                                           : IDX_W'(count_reg - CNT_W'(1));
                chain.load_value = do_push ? val_reg : front_value;
                if (do_push)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else if (do_drop)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                if (capture)
                begin
                    res_next = front_value;
                end
                if (do_drop && (op_reg == OP_REMOVE_VALUE))
                begin
                    ok_next = 1'b1;
                end
                step_next = step_reg + CNT_W'(1);
                if (step_reg == steps_reg - CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        steps_reg <= steps_next;
        idx_reg   <= idx_next;
        op_reg    <= op_next;
        val_reg   <= val_next;
        res_reg   <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = (state_reg == ST_DONE);
    assign ok           = ok_reg;
    assign result_value = res_reg;
    assign length_after = LEN_W'(count_reg);

endmodule

@@ rtl/positional_list_engine.sv @@
// Top level of the positional list engine: a chain of element cells driven
// by the step sequencer. Depends on ple_pkg, ple_cell and ple_ctrl.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. The list lives in a
// circular chain of CAPACITY cells with the front in cell 0; every operation
// rotates the whole list once, one element per cycle, dropping, capturing or
// inserting at the right step. The walk has one step per element of the list
// before the item, and one more step for insertions; it is followed by the
// result state, in which the result is shown with done high. Failures that
// are known up front (full, empty, bad position, unknown code) skip the walk
// and go straight to the result state. The result is valid for exactly the
// cycle done is high and cannot be stalled; busy stays high until that cycle
// has passed.

module positional_list_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ple_pkg::OP_W-1:0]  operation,
    input  logic [ple_pkg::POS_W-1:0] position,
    input  logic signed [ple_pkg::VAL_W-1:0] item_value,
    output logic                      done,
    output logic                      ok,
    output logic signed [ple_pkg::VAL_W-1:0] result_value,
    output logic [ple_pkg::LEN_W-1:0] length_after
);
    import ple_pkg::*;

    chain_ctl_t       chain;
    logic [VAL_W-1:0] cell_value [CAPACITY+1];
    logic [VAL_W-1:0] res_u;

    assign cell_value[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ple_cell u_cell (
            .clk         (clk),
            .ctl         (chain),
            .sel         (chain.tgt == IDX_W'(i)),
            .right_value (cell_value[i+1]),
            .value       (cell_value[i])
        );
    end

    ple_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .position     (position),
        .item_value   (item_value),
        .front_value  (cell_value[0]),
        .chain        (chain),
        .done         (done),
        .ok           (ok),
        .result_value (res_u),
        .length_after (length_after)
    );

    assign result_value = res_u;

endmodule

@@ bench/positional_list_engine_test.sv @@
// Self-checking bench for positional_list_engine: sends list operations, keeps a
// shadow list to predict each result and checks every done strobe against it.
// Depends on ple_pkg and the positional_list_engine RTL.
`timescale 1ns / 1ps

module positional_list_engine_test;
    import ple_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
    localparam int MAX_REPORTS   = 10;

    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 4'd9;
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 4'd15;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] value;
        logic [LEN_W-1:0] length;
    } list_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
    logic                    done;
    logic                    ok;
    logic signed [VAL_W-1:0] result_value;
    logic [LEN_W-1:0]        length_after;

    logic signed [VAL_W-1:0] shadow_list[$];
    list_result_t            pending_results[$];

    bit          idle_enable    = 1'b0;
    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned full_refusals  = 0;
    int unsigned empty_ops      = 0;
    int unsigned failed_ops     = 0;

    positional_list_engine u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .position     (position),
        .item_value   (item_value),
        .done         (done),
        .ok           (ok),
        .result_value (result_value),
        .length_after (length_after)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Applies one operation to the shadow list and returns the expected result.
    function automatic list_result_t predict_list_op(input logic [OP_W-1:0] op,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic signed [VAL_W-1:0] val);
        list_result_t            r;
        int                      len;
        int                      p;
        int                      k;
        bit                      found;
        logic signed [VAL_W-1:0] kept[$];
        r     = '0;
        len   = shadow_list.size();
        p     = pos;
        found = 1'b0;
        if (len == CAPACITY && op <= OP_INSERT_AT)
            full_refusals++;
        if (len == 0)
            empty_ops++;
        case (op)
            OP_APPEND:
                if (len < CAPACITY)
                begin
                    shadow_list.push_back(val);
                    r.ok = 1'b1;
                end
            OP_PREPEND:
                if (len < CAPACITY)
                begin
                    shadow_list.push_front(val);
                    r.ok = 1'b1;
                end
            OP_INSERT_AT:
                if (len < CAPACITY && p >= 1 && p <= len + 1)
                begin
                    shadow_list.insert(p - 1, val);
                    r.ok = 1'b1;
                end
            OP_POP_FRONT:
                if (len > 0)
                begin
                    r.value = shadow_list.pop_front();
                    r.ok    = 1'b1;
                end
            OP_POP_BACK:
                if (len > 0)
                begin
                    r.value = shadow_list.pop_back();
                    r.ok    = 1'b1;
                end
            OP_REMOVE_AT:
                if (p >= 1 && p <= len)
                begin
                    r.value = shadow_list[p - 1];
                    shadow_list.delete(p - 1);
                    r.ok    = 1'b1;
                end
            OP_REMOVE_VALUE:
                for (k = 0; k < len; k++)
                begin
                    if (!found && shadow_list[k] == val)
                    begin
                        found   = 1'b1;
                        r.value = shadow_list[k];
                        shadow_list.delete(k);
                        r.ok    = 1'b1;
                    end
                end
            OP_REMOVE_EVEN:
                if (len > 0)
                begin
                    for (k = 0; k < len; k++)
                    begin
                        if (shadow_list[k][0])
                            kept.push_back(shadow_list[k]);
                    end
                    shadow_list = kept;
                    r.ok        = 1'b1;
                end
            OP_READ_AT:
                if (p >= 1 && p <= len)
                begin
                    r.value = shadow_list[p - 1];
                    r.ok    = 1'b1;
                end
            default:
                ;
        endcase
        if (!r.ok)
            failed_ops++;
        r.length = LEN_W'(shadow_list.size());
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3, 4, 5: return $urandom_range(16) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_search_value();
        if (shadow_list.size() > 0 && $urandom_range(9) < 7)
            return shadow_list[$urandom_range(shadow_list.size() - 1)];
        return pick_value();
    endfunction

    // Mostly in range; one in ten anywhere in the field.
    function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
        int upper;
        upper = shadow_list.size() + ((op == OP_INSERT_AT) ? 1 : 0);
        if (upper == 0 || $urandom_range(9) == 0)
            return POS_W'($urandom);
        return POS_W'($urandom_range(upper, 1));
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic signed [VAL_W-1:0] val);
        int gap;
        if (idle_enable && $urandom_range(99) < 19)
        begin
            gap = $urandom_range(20, 1);
            repeat (gap) @(negedge clk);
        end
        @(negedge clk);
        start      <= 1'b1;
        operation  <= op;
        position   <= pos;
        item_value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_list_op(op, pos, val));
        items_sent++;
        @(negedge clk);
        start      <= 1'b0;
        operation  <= OP_W'($urandom);
        position   <= POS_W'($urandom);
        item_value <= $urandom;
    endtask

    task automatic send_random_insert();
        case ($urandom_range(2))
            0:       send_item(OP_APPEND, POS_W'($urandom), pick_value());
            1:       send_item(OP_PREPEND, POS_W'($urandom), pick_value());
            default: send_item(OP_INSERT_AT, pick_position(OP_INSERT_AT), pick_value());
        endcase
    endtask

    task automatic send_random_removal();
        case ($urandom_range(11))
            0, 1, 2: send_item(OP_POP_FRONT, POS_W'($urandom), $urandom);
            3, 4, 5: send_item(OP_POP_BACK, POS_W'($urandom), $urandom);
            6, 7, 8: send_item(OP_REMOVE_AT, pick_position(OP_REMOVE_AT), $urandom);
            9, 10:   send_item(OP_REMOVE_VALUE, POS_W'($urandom), pick_search_value());
            default: send_item(OP_REMOVE_EVEN, POS_W'($urandom), $urandom);
        endcase
    endtask

    task automatic hold_until_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_list();
        send_item(OP_READ_AT, 5'd1, '0);
        send_item(OP_POP_FRONT, '0, '0);
        send_item(OP_POP_BACK, '0, '0);
        send_item(OP_REMOVE_AT, 5'd1, '0);
        send_item(OP_REMOVE_VALUE, '0, '0);
        send_item(OP_REMOVE_EVEN, '0, '0);
        send_item(OP_LAST_UNUSED, 5'd31, -1);
    endtask

    task automatic test_positions_and_extremes();
        send_item(OP_INSERT_AT, 5'd0, 32'sd5);
        send_item(OP_INSERT_AT, 5'd2, 32'sd5);
        send_item(OP_INSERT_AT, 5'd1, VAL_MIN);
        send_item(OP_APPEND, '0, VAL_MAX);
        send_item(OP_PREPEND, '0, -2);
        send_item(OP_INSERT_AT, 5'd4, '0);
        send_item(OP_INSERT_AT, 5'd6, 32'sd1);
        send_item(OP_READ_AT, 5'd0, '0);
        send_item(OP_READ_AT, 5'd4, '0);
        send_item(OP_READ_AT, 5'd5, '0);
        send_item(OP_REMOVE_AT, 5'd31, '0);
        send_item(OP_REMOVE_VALUE, '0, 32'sd7);
        send_item(OP_REMOVE_VALUE, '0, VAL_MIN);
        send_item(OP_APPEND, '0, -1);
        send_item(OP_REMOVE_EVEN, '0, '0);
        // nothing even left: still succeeds
        send_item(OP_REMOVE_EVEN, '0, '0);
        send_item(OP_REMOVE_AT, 5'd2, '0);
        send_item(OP_POP_BACK, '0, '0);
    endtask

    task automatic test_fill_and_drain(input int rounds);
        repeat (rounds)
        begin
            while (shadow_list.size() < CAPACITY)
                send_random_insert();
            send_item(OP_APPEND, POS_W'($urandom), pick_value());
            send_item(OP_PREPEND, POS_W'($urandom), pick_value());
            send_item(OP_INSERT_AT, POS_W'($urandom), pick_value());
            repeat ($urandom_range(6, 2))
                send_item(OP_READ_AT, pick_position(OP_READ_AT), $urandom);
            while (shadow_list.size() > 0)
                send_random_removal();
            send_item(OP_POP_FRONT, POS_W'($urandom), $urandom);
        end
    endtask

    task automatic test_random_mix(input int count);
        int unsigned r;
        int unsigned ins_weight;
        repeat (count)
        begin
            r          = $urandom_range(99);
            ins_weight = (shadow_list.size() > CAPACITY / 2 + 2) ? 35 : 50;
            if (r < 3)
                send_item(OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED)),
                          POS_W'($urandom), $urandom);
            else if (r < 3 + ins_weight)
                send_random_insert();
            else if (r < 87)
                send_random_removal();
            else
                send_item(OP_READ_AT, pick_position(OP_READ_AT), $urandom);
        end
    endtask

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with no item outstanding: ok=%0b value=%0d len=%0d",
                             $time, ok, result_value, length_after);
            end
            else
            begin
                want = pending_results.pop_front();
                if (ok !== want.ok || result_value !== want.value
                    || length_after !== want.length)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: expected ok=%0b value=%0d len=%0d, got %0b %0d %0d",
                                 $time, want.ok, $signed(want.value), want.length,
                                 ok, result_value, length_after);
                end
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        operation  = '0;
        position   = '0;
        item_value = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_enable = 1'b1;
        test_empty_list();
        test_positions_and_extremes();
        hold_until_drained();
        test_fill_and_drain(2);
        test_random_mix(200);
        idle_enable = 1'b0;
        test_random_mix(150);
        idle_enable = 1'b1;
        hold_until_drained();
        test_fill_and_drain(2);
        test_random_mix(150);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            mismatch_count += pending_results.size();
        $display("%0d items sent, %0d results checked, %0d mismatches",
                 items_sent, results_seen, mismatch_count);
        $display("%0d failed ops: %0d inserts into a full list, %0d ops on an empty list",
                 failed_ops, full_refusals, empty_ops);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine.sv
bench/positional_list_engine_test.sv
